>>> hw/rtl/srn_pkg.sv
package srn_pkg;

   // Set capacity and derived widths
   localparam int MAX_FACES = 16;
   localparam int IDX_W     = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int CNT_W     = $clog2(MAX_FACES + 1);

   // Fixed field widths
   localparam int KIND_W   = 2;
   localparam int FACE_W   = 16;
   localparam int NAME_W   = 64;
   localparam int DRAW_W   = 16;
   localparam int FCOUNT_W = 5;
   localparam int STATUS_W = 2;
   localparam int BIT_W    = $clog2(DRAW_W);

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_CHANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Sequencer states
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_MOD  = 5'b00100,
      S_PICK = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

endpackage

>>> hw/rtl/srn_req_if.sv
interface srn_req_if;
   logic                           valid;
   logic                           ready;
   logic [srn_pkg::KIND_W-1:0]     kind;
   logic [srn_pkg::FACE_W-1:0]     face_id;
   logic [srn_pkg::FACE_W-1:0]     ingress_face;
   logic [srn_pkg::NAME_W-1:0]     name_high;
   logic [srn_pkg::NAME_W-1:0]     name_low;
   logic [srn_pkg::DRAW_W-1:0]     random_draw;

   modport source (output valid, kind, face_id, ingress_face, name_high, name_low,
                   random_draw, input ready);
   modport sink   (input valid, kind, face_id, ingress_face, name_high, name_low,
                   random_draw, output ready);
endinterface

>>> hw/rtl/srn_rsp_if.sv
interface srn_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            has_face;
   logic [srn_pkg::FACE_W-1:0]      out_face;
   logic [srn_pkg::FCOUNT_W-1:0]    face_count;
   logic [srn_pkg::STATUS_W-1:0]    status;

   modport source (output valid, has_face, out_face, face_count, status, input ready);
   modport sink   (input valid, has_face, out_face, face_count, status, output ready);
endinterface

>>> hw/rtl/sticky_random_nexthop_select.sv
// Each accepted request scans the set member by member; add, remove and lookups
// that give no face or reuse the sticky face then respond. A fresh pick runs the
// 16-bit serial remainder unit, then one table read; unknown kinds skip the scan.
// Throughput: one transaction at a time, the next accepted once the result is taken.
// The single scan pointer over the face table and the bit-serial remainder set the pace.
// Reset (synchronous, active high) empties the set and clears the stored name.
module sticky_random_nexthop_select (
   input  logic     clock,
   input  logic     reset,
   srn_req_if.sink  req,
   srn_rsp_if.source rsp
);

   srn_pkg::state_type state_ff, state_in;

   // Face set
   logic [srn_pkg::FACE_W-1:0] table_ff [srn_pkg::MAX_FACES];
   logic [srn_pkg::FACE_W-1:0] table_in [srn_pkg::MAX_FACES];
   logic [srn_pkg::CNT_W-1:0]  count_ff, count_in;

   // Sticky state
   logic [srn_pkg::NAME_W-1:0] seg_high_ff, seg_high_in;
   logic [srn_pkg::NAME_W-1:0] seg_low_ff, seg_low_in;
   logic                       seg_valid_ff, seg_valid_in;
   logic [srn_pkg::FACE_W-1:0] last_face_ff, last_face_in;

   // Captured transaction
   logic [srn_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [srn_pkg::FACE_W-1:0] face_ff, face_in;
   logic [srn_pkg::FACE_W-1:0] ingress_ff, ingress_in;
   logic [srn_pkg::NAME_W-1:0] name_high_ff, name_high_in;
   logic [srn_pkg::NAME_W-1:0] name_low_ff, name_low_in;
   logic [srn_pkg::DRAW_W-1:0] draw_ff, draw_in;

   // Scan and remainder unit
   logic [srn_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic                       hit_key_ff, hit_key_in;
   logic [srn_pkg::IDX_W-1:0]  key_pos_ff, key_pos_in;
   logic                       hit_ing_ff, hit_ing_in;
   logic [srn_pkg::IDX_W-1:0]  ing_pos_ff, ing_pos_in;
   logic [srn_pkg::CNT_W-1:0]  elig_ff, elig_in;
   logic [srn_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [srn_pkg::BIT_W-1:0]  bit_ff, bit_in;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_has_ff, rsp_has_in;
   logic [srn_pkg::FACE_W-1:0]    rsp_face_ff, rsp_face_in;
   logic [srn_pkg::FCOUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [srn_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [srn_pkg::FACE_W-1:0] rd_face;
   logic [srn_pkg::FACE_W-1:0] key_face;
   logic                       name_match;
   logic [srn_pkg::CNT_W:0]    rem_sh;
   logic [srn_pkg::CNT_W-1:0]  rem_next;
   logic [srn_pkg::CNT_W-1:0]  target;
   logic [srn_pkg::CNT_W-1:0]  elig_calc;

   // Single read port of the face table
   assign rd_face    = table_ff[idx_ff[srn_pkg::IDX_W-1:0]];
   assign key_face   = (kind_ff == srn_pkg::KIND_LOOKUP) ? last_face_ff : face_ff;
   assign name_match = seg_valid_ff && (seg_high_ff == name_high_ff) &&
                       (seg_low_ff == name_low_ff);
   assign elig_calc  = count_ff - srn_pkg::CNT_W'(hit_ing_ff);

   // Remainder step: shift in one draw bit, subtract the divisor when it fits
   assign rem_sh   = {rem_ff, draw_ff[bit_ff]};
   assign rem_next = (rem_sh >= {1'b0, elig_ff}) ?
                     srn_pkg::CNT_W'(rem_sh - {1'b0, elig_ff}) :
                     rem_sh[srn_pkg::CNT_W-1:0];
   assign target   = rem_next;

   assign req.ready      = (state_ff == srn_pkg::S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.has_face   = rsp_has_ff;
   assign rsp.out_face   = rsp_face_ff;
   assign rsp.face_count = rsp_count_ff;
   assign rsp.status     = rsp_status_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      for (int j = 0; j < srn_pkg::MAX_FACES; j++) begin
         table_in[j] = table_ff[j];
      end
      count_in      = count_ff;
      seg_high_in   = seg_high_ff;
      seg_low_in    = seg_low_ff;
      seg_valid_in  = seg_valid_ff;
      last_face_in  = last_face_ff;
      kind_in       = kind_ff;
      face_in       = face_ff;
      ingress_in    = ingress_ff;
      name_high_in  = name_high_ff;
      name_low_in   = name_low_ff;
      draw_in       = draw_ff;
      idx_in        = idx_ff;
      hit_key_in    = hit_key_ff;
      key_pos_in    = key_pos_ff;
      hit_ing_in    = hit_ing_ff;
      ing_pos_in    = ing_pos_ff;
      elig_in       = elig_ff;
      rem_in        = rem_ff;
      bit_in        = bit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_face_in   = rsp_face_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         srn_pkg::S_IDLE: begin
            // Capture the transaction and start the scan
            if (req.valid) begin
               kind_in      = req.kind;
               face_in      = req.face_id;
               ingress_in   = req.ingress_face;
               name_high_in = req.name_high;
               name_low_in  = req.name_low;
               draw_in      = req.random_draw;
               idx_in       = '0;
               hit_key_in   = 1'b0;
               hit_ing_in   = 1'b0;
               key_pos_in   = '0;
               ing_pos_in   = '0;
               if ((req.kind == srn_pkg::KIND_LOOKUP) || (req.kind == srn_pkg::KIND_ADD) ||
                   (req.kind == srn_pkg::KIND_REMOVE)) begin
                  state_in = srn_pkg::S_SCAN;
               end else begin
                  // Unknown kind: ignore
                  rsp_valid_in  = 1'b1;
                  rsp_has_in    = 1'b0;
                  rsp_face_in   = '0;
                  rsp_count_in  = srn_pkg::FCOUNT_W'(count_ff);
                  rsp_status_in = srn_pkg::STATUS_NO_CHANGE;
                  state_in      = srn_pkg::S_RESP;
               end
            end
         end

         srn_pkg::S_SCAN: begin
            if (idx_ff != count_ff) begin
               // Compare one member against the key and the ingress face
               if (rd_face == key_face) begin
                  hit_key_in = 1'b1;
                  key_pos_in = idx_ff[srn_pkg::IDX_W-1:0];
               end
               if (rd_face == ingress_ff) begin
                  hit_ing_in = 1'b1;
                  ing_pos_in = idx_ff[srn_pkg::IDX_W-1:0];
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               // Scan over: decide
               rsp_has_in    = 1'b0;
               rsp_face_in   = '0;
               rsp_status_in = srn_pkg::STATUS_DONE;
               state_in      = srn_pkg::S_RESP;
               rsp_valid_in  = 1'b1;
               if (kind_ff == srn_pkg::KIND_ADD) begin
                  if (hit_key_ff) begin
                     rsp_status_in = srn_pkg::STATUS_NO_CHANGE;
                  end else if (count_ff >= srn_pkg::CNT_W'(srn_pkg::MAX_FACES)) begin
                     rsp_status_in = srn_pkg::STATUS_FULL;
                  end else begin
                     table_in[count_ff[srn_pkg::IDX_W-1:0]] = face_ff;
                     count_in = count_ff + 1'b1;
                  end
               end else if (kind_ff == srn_pkg::KIND_REMOVE) begin
                  if (hit_key_ff) begin
                     // Close the gap, keeping set order
                     for (int j = 0; j < srn_pkg::MAX_FACES - 1; j++) begin
                        if (j >= int'(key_pos_ff)) begin
                           table_in[j] = table_ff[j+1];
                        end
                     end
                     count_in = count_ff - 1'b1;
                  end else begin
                     rsp_status_in = srn_pkg::STATUS_NO_CHANGE;
                  end
               end else begin
                  priority if ((count_ff == '0) ||
                               ((count_ff == srn_pkg::CNT_W'(1)) && hit_ing_ff)) begin
                     // Nothing to forward to
                  end else if (name_match && hit_key_ff) begin
                     rsp_has_in  = 1'b1;
                     rsp_face_in = last_face_ff;
                  end else begin
                     if (!name_match) begin
                        seg_high_in  = name_high_ff;
                        seg_low_in   = name_low_ff;
                        seg_valid_in = 1'b1;
                     end
                     if (elig_calc != '0) begin
                        // Hand over to the remainder unit
                        elig_in      = elig_calc;
                        rem_in       = '0;
                        bit_in       = srn_pkg::BIT_W'(srn_pkg::DRAW_W - 1);
                        rsp_valid_in = 1'b0;
                        state_in     = srn_pkg::S_MOD;
                     end
                  end
               end
               rsp_count_in = srn_pkg::FCOUNT_W'(count_in);
            end
         end

         srn_pkg::S_MOD: begin
            // One remainder bit a cycle, most significant first
            rem_in = rem_next;
            if (bit_ff == '0) begin
               // Skip over the ingress face in set order
               if (hit_ing_ff && (target >= srn_pkg::CNT_W'(ing_pos_ff))) begin
                  idx_in = target + 1'b1;
               end else begin
                  idx_in = target;
               end
               state_in = srn_pkg::S_PICK;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end

         srn_pkg::S_PICK: begin
            last_face_in  = rd_face;
            rsp_valid_in  = 1'b1;
            rsp_has_in    = 1'b1;
            rsp_face_in   = rd_face;
            rsp_count_in  = srn_pkg::FCOUNT_W'(count_ff);
            rsp_status_in = srn_pkg::STATUS_DONE;
            state_in      = srn_pkg::S_RESP;
         end

         srn_pkg::S_RESP: begin
            // Hold the result until taken
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = srn_pkg::S_IDLE;
            end
         end

         default: begin
            state_in     = srn_pkg::S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srn_pkg::S_IDLE;
         count_ff     <= '0;
         seg_high_ff  <= '0;
         seg_low_ff   <= '0;
         seg_valid_ff <= 1'b0;
         last_face_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         seg_high_ff  <= seg_high_in;
         seg_low_ff   <= seg_low_in;
         seg_valid_ff <= seg_valid_in;
         last_face_ff <= last_face_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int j = 0; j < srn_pkg::MAX_FACES; j++) begin
         table_ff[j] <= table_in[j];
      end
      kind_ff       <= kind_in;
      face_ff       <= face_in;
      ingress_ff    <= ingress_in;
      name_high_ff  <= name_high_in;
      name_low_ff   <= name_low_in;
      draw_ff       <= draw_in;
      idx_ff        <= idx_in;
      hit_key_ff    <= hit_key_in;
      key_pos_ff    <= key_pos_in;
      hit_ing_ff    <= hit_ing_in;
      ing_pos_ff    <= ing_pos_in;
      elig_ff       <= elig_in;
      rem_ff        <= rem_in;
      bit_ff        <= bit_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_face_ff   <= rsp_face_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Checks
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid)
      else $error("request taken while a result is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= srn_pkg::CNT_W'(srn_pkg::MAX_FACES))
      else $error("member count beyond capacity");

   a_face_status: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.has_face) |-> (rsp.status == srn_pkg::STATUS_DONE))
      else $error("face given with a non-done status");

   a_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srn_pkg::S_MOD) |-> ((elig_ff != '0) && (elig_ff <= count_ff)))
      else $error("remainder unit running with a bad divisor");

endmodule
